// ===== hdl/svg_pkg.sv =====
// Shared types and constants of the state-vector gate engine.
package svg_pkg;

   localparam int CSR_W = 4;
   localparam logic [CSR_W-1:0] QUBITS_RESET = 4'd10;
   localparam int SHIFT_W = 6;
   localparam logic [16:0] INV_SQRT2_Q16 = 17'd46341;

   typedef enum logic [2:0] {
      OP_WRITE = 3'd0,
      OP_READ  = 3'd1,
      OP_X     = 3'd2,
      OP_Y     = 3'd3,
      OP_Z     = 3'd4,
      OP_H     = 3'd5,
      OP_SWAP  = 3'd6,
      OP_RSVD  = 3'd7
   } op_type;

   typedef struct packed {
      logic               load;
      logic               clear;
      logic               negate;
      logic               multiply;
      logic               use_h;
      logic               use_prod;
      logic [1:0]         ipow;
      logic [SHIFT_W-1:0] shift;
   } alu_ctrl_type;

endpackage

// ===== hdl/svg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module svg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_data_ff <= mem[raddr];
   end

   assign rdata = rd_data_ff;

endmodule

// ===== hdl/svg_alu.sv =====
// Shared arithmetic unit: signed accumulate, scale by 1/sqrt2, round, saturate, i-power.
module svg_alu #(
   parameter int AMP_W = 16,
   parameter int ACC_W = 27
) (
   input  logic                     clock,
   input  svg_pkg::alu_ctrl_type    ctl,
   input  logic signed [AMP_W-1:0]  in_re,
   input  logic signed [AMP_W-1:0]  in_im,
   output logic signed [AMP_W-1:0]  out_re,
   output logic signed [AMP_W-1:0]  out_im
);
   import svg_pkg::*;

   localparam int PROD_W = ACC_W + 18;

   logic signed [ACC_W-1:0]  acc_re_ff, acc_re_in, acc_im_ff, acc_im_in;
   logic signed [PROD_W-1:0] prod_re_ff, prod_re_in, prod_im_ff, prod_im_in;
   logic signed [ACC_W-1:0]  term_re, term_im;
   logic signed [17:0]       inv_s;
   logic signed [AMP_W-1:0]  ip_re, ip_im;

   function automatic logic signed [AMP_W-1:0] neg_sat(input logic signed [AMP_W-1:0] x);
      if (x == {1'b1, {(AMP_W-1){1'b0}}}) begin
         return {1'b0, {(AMP_W-1){1'b1}}};
      end
      return -x;
   endfunction

   // Round to nearest with ties upwards, then saturate to the amplitude width.
   function automatic logic signed [AMP_W-1:0] round_sat(input logic signed [PROD_W-1:0] v,
                                                        input logic [SHIFT_W-1:0] sh);
      logic signed [PROD_W:0] sum;
      logic signed [PROD_W:0] half;
      logic signed [PROD_W:0] q;
      logic [PROD_W-AMP_W+1:0] upper;
      half = '0;
      if (sh != '0) begin
         half = (PROD_W+1)'(1) << (sh - SHIFT_W'(1));
      end
      sum = (PROD_W+1)'(v) + half;
      q = sum >>> sh;
      upper = q[PROD_W:AMP_W-1];
      if ((upper == '0) || (upper == '1)) begin
         return q[AMP_W-1:0];
      end
      return q[PROD_W] ? {1'b1, {(AMP_W-1){1'b0}}} : {1'b0, {(AMP_W-1){1'b1}}};
   endfunction

   assign inv_s = $signed({1'b0, INV_SQRT2_Q16});

   always_comb begin
      term_re = ACC_W'(in_re);
      term_im = ACC_W'(in_im);
      if (ctl.negate) begin
         term_re = -term_re;
         term_im = -term_im;
      end
      acc_re_in = acc_re_ff;
      acc_im_in = acc_im_ff;
      if (ctl.load) begin
         acc_re_in = ctl.clear ? term_re : acc_re_ff + term_re;
         acc_im_in = ctl.clear ? term_im : acc_im_ff + term_im;
      end
      prod_re_in = prod_re_ff;
      prod_im_in = prod_im_ff;
      if (ctl.multiply) begin
         prod_re_in = acc_re_ff * inv_s;
         prod_im_in = acc_im_ff * inv_s;
      end
   end

   always_ff @(posedge clock) begin
      acc_re_ff  <= acc_re_in;
      acc_im_ff  <= acc_im_in;
      prod_re_ff <= prod_re_in;
      prod_im_ff <= prod_im_in;
   end

   always_comb begin
      case (ctl.ipow)
         2'd0: begin
            ip_re = acc_re_ff[AMP_W-1:0];
            ip_im = acc_im_ff[AMP_W-1:0];
         end
         2'd1: begin
            ip_re = neg_sat(acc_im_ff[AMP_W-1:0]);
            ip_im = acc_re_ff[AMP_W-1:0];
         end
         2'd2: begin
            ip_re = neg_sat(acc_re_ff[AMP_W-1:0]);
            ip_im = neg_sat(acc_im_ff[AMP_W-1:0]);
         end
         default: begin
            ip_re = acc_im_ff[AMP_W-1:0];
            ip_im = neg_sat(acc_re_ff[AMP_W-1:0]);
         end
      endcase
      if (ctl.use_h) begin
         out_re = round_sat(ctl.use_prod ? prod_re_ff : PROD_W'(acc_re_ff), ctl.shift);
         out_im = round_sat(ctl.use_prod ? prod_im_ff : PROD_W'(acc_im_ff), ctl.shift);
      end else begin
         out_re = ip_re;
         out_im = ip_im;
      end
   end

endmodule

// ===== hdl/state_vector_gate_engine_unit.sv =====
// Top level of the state-vector gate engine: sequencer, amplitude banks and shared unit.
//
// Amplitudes live in two RAMs used as a ping-pong pair; a gate reads the current bank,
// writes the other and then swaps them. Each item returns exactly one result, shown for
// one cycle on rsp_strobe; the receiver cannot stall it. busy is high from the cycle after
// the transfer through the result. A write or a rejected item goes straight to the
// response; a read passes through the read and capture states first. A gate runs one
// amplitude at a time through the single read port and the shared arithmetic unit,
// through read, accumulate and write states per amplitude for X, Y, Z and SWAP.
// H with k target bits reads 2^k amplitudes per output, with an extra multiply state per
// output for odd k; an output whose controls are not all set is copied with one read.
module state_vector_gate_engine_unit #(
   parameter int MAX_QUBITS = 10,
   parameter int AMP_WIDTH  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [2:0]                    req_opcode,
   input  logic [MAX_QUBITS-1:0]         req_amp_index,
   input  logic signed [AMP_WIDTH-1:0]   req_amp_real,
   input  logic signed [AMP_WIDTH-1:0]   req_amp_imag,
   input  logic [MAX_QUBITS-1:0]         req_target_mask,
   input  logic [MAX_QUBITS-1:0]         req_control_mask,
   input  logic                          csr_write_enable,
   input  logic [svg_pkg::CSR_W-1:0]     csr_write_data,
   output logic                          rsp_strobe,
   output logic signed [AMP_WIDTH-1:0]   rsp_read_real,
   output logic signed [AMP_WIDTH-1:0]   rsp_read_imag,
   output logic                          rsp_status
);
   import svg_pkg::*;

   localparam int QW    = MAX_QUBITS;
   localparam int AW    = AMP_WIDTH;
   localparam int ACC_W = AW + QW + 1;
   localparam int K_W   = $clog2(QW + 1);
   localparam int DEPTH = 1 << QW;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_RD   = 6'b000010,
      ST_AC   = 6'b000100,
      ST_MUL  = 6'b001000,
      ST_WR   = 6'b010000,
      ST_RSP  = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   logic [CSR_W-1:0]   qubits_ff, qubits_in;
   logic               bank_ff, bank_in;
   op_type             op_ff, op_in;
   logic [QW-1:0]      idx_ff, idx_in;
   logic [QW-1:0]      tm_ff, tm_in;
   logic [QW-1:0]      cm_ff, cm_in;
   logic [K_W-1:0]     k_ff, k_in;
   logic [QW-1:0]      s_ff, s_in;
   logic [QW-1:0]      u_ff, u_in;
   logic [AW-1:0]      res_re_ff, res_re_in, res_im_ff, res_im_in;
   logic               status_ff, status_in;

   int                 q_eff;
   logic [QW-1:0]      valid_mask;
   op_type             req_op;
   logic [K_W-1:0]     req_k;
   logic               reject;
   logic               accept;

   logic               act;
   logic               use_h;
   logic [QW-1:0]      u_next;
   logic [QW-1:0]      swap_lo, swap_hi;
   logic [QW-1:0]      rd_addr;
   logic [1:0]         ipow;
   alu_ctrl_type       ctl;

   logic [2*AW-1:0]    rdata_a, rdata_b, cur_data, wdata;
   logic               we_a, we_b;
   logic [QW-1:0]      waddr;
   logic signed [AW-1:0] alu_re, alu_im;

   always_comb begin
      q_eff = int'(qubits_ff);
      if (q_eff == 0) begin
         q_eff = 1;
      end
      if (q_eff > QW) begin
         q_eff = QW;
      end
      for (int i = 0; i < QW; i++) begin
         valid_mask[i] = (i < q_eff);
      end
   end

   assign req_op = op_type'(req_opcode);
   assign req_k  = K_W'($countones(req_target_mask));
   assign accept = start && (state_ff == ST_IDLE);

   // Gate checks; writes and reads are never rejected.
   assign reject = (req_op == OP_RSVD)
                || ((req_op != OP_WRITE) && (req_op != OP_READ)
                    && ((req_target_mask == '0)
                        || ((req_target_mask & ~valid_mask) != '0)
                        || ((req_control_mask & ~valid_mask) != '0)
                        || ((req_target_mask & req_control_mask) != '0)
                        || ((req_op == OP_SWAP) && (req_k != K_W'(2)))));

   always_comb begin
      act     = ((s_ff & cm_ff) == cm_ff);
      use_h   = (op_ff == OP_H) && act;
      u_next  = (u_ff - tm_ff) & tm_ff;
      swap_lo = tm_ff & (-tm_ff);
      swap_hi = tm_ff ^ swap_lo;
      rd_addr = s_ff;
      if (op_ff == OP_READ) begin
         rd_addr = idx_ff;
      end else if (act) begin
         case (op_ff)
            OP_X, OP_Y: rd_addr = s_ff ^ tm_ff;
            OP_H:       rd_addr = (s_ff & ~tm_ff) | u_ff;
            OP_SWAP: begin
               if (((s_ff & swap_lo) != '0) != ((s_ff & swap_hi) != '0)) begin
                  rd_addr = s_ff ^ tm_ff;
               end
            end
            default:    rd_addr = s_ff;
         endcase
      end
      ipow = 2'd0;
      if (act && (op_ff == OP_Y)) begin
         ipow = 2'(2 * $countones(s_ff & tm_ff) + 3 * int'(k_ff));
      end else if (act && (op_ff == OP_Z)) begin
         ipow = 2'(2 * $countones(s_ff & tm_ff));
      end
   end

   always_comb begin
      ctl          = '0;
      ctl.use_h    = use_h;
      ctl.use_prod = k_ff[0];
      ctl.ipow     = ipow;
      ctl.shift    = k_ff[0] ? SHIFT_W'(16 + (int'(k_ff) - 1) / 2) : SHIFT_W'(int'(k_ff) / 2);
      ctl.load     = (state_ff == ST_AC) && (op_ff != OP_READ);
      ctl.clear    = (u_ff == '0) || !use_h;
      ctl.negate   = use_h && (^(s_ff & u_ff));
      ctl.multiply = (state_ff == ST_MUL);
   end

   assign cur_data = bank_ff ? rdata_b : rdata_a;

   always_comb begin
      state_in  = state_ff;
      qubits_in = csr_write_enable ? csr_write_data : qubits_ff;
      bank_in   = bank_ff;
      op_in     = op_ff;
      idx_in    = idx_ff;
      tm_in     = tm_ff;
      cm_in     = cm_ff;
      k_in      = k_ff;
      s_in      = s_ff;
      u_in      = u_ff;
      res_re_in = res_re_ff;
      res_im_in = res_im_ff;
      status_in = status_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in     = req_op;
               idx_in    = req_amp_index & valid_mask;
               tm_in     = req_target_mask;
               cm_in     = req_control_mask;
               k_in      = req_k;
               s_in      = '0;
               u_in      = '0;
               res_re_in = '0;
               res_im_in = '0;
               status_in = reject;
               if (reject || (req_op == OP_WRITE)) begin
                  state_in = ST_RSP;
               end else begin
                  state_in = ST_RD;
               end
            end
         end
         ST_RD: begin
            state_in = ST_AC;
         end
         ST_AC: begin
            if (op_ff == OP_READ) begin
               res_re_in = cur_data[2*AW-1:AW];
               res_im_in = cur_data[AW-1:0];
               state_in  = ST_RSP;
            end else if (use_h && (u_next != '0)) begin
               u_in     = u_next;
               state_in = ST_RD;
            end else if (use_h && k_ff[0]) begin
               state_in = ST_MUL;
            end else begin
               state_in = ST_WR;
            end
         end
         ST_MUL: begin
            state_in = ST_WR;
         end
         ST_WR: begin
            u_in = '0;
            if (s_ff == valid_mask) begin
               bank_in  = !bank_ff;
               state_in = ST_RSP;
            end else begin
               s_in     = s_ff + QW'(1);
               state_in = ST_RD;
            end
         end
         ST_RSP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         qubits_ff <= QUBITS_RESET;
         bank_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         qubits_ff <= qubits_in;
         bank_ff   <= bank_in;
      end
      op_ff     <= op_in;
      idx_ff    <= idx_in;
      tm_ff     <= tm_in;
      cm_ff     <= cm_in;
      k_ff      <= k_in;
      s_ff      <= s_in;
      u_ff      <= u_in;
      res_re_ff <= res_re_in;
      res_im_ff <= res_im_in;
      status_ff <= status_in;
   end

   // An amplitude write goes to the current bank; a gate writes the other one.
   always_comb begin
      we_a  = (accept && (req_op == OP_WRITE) && !bank_ff) || ((state_ff == ST_WR) && bank_ff);
      we_b  = (accept && (req_op == OP_WRITE) && bank_ff) || ((state_ff == ST_WR) && !bank_ff);
      waddr = (state_ff == ST_WR) ? s_ff : (req_amp_index & valid_mask);
      wdata = (state_ff == ST_WR) ? {alu_re, alu_im} : {req_amp_real, req_amp_imag};
   end

   svg_ram #(.WIDTH(2*AW), .DEPTH(DEPTH)) u_bank_a (
      .clock (clock),
      .we    (we_a),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (rd_addr),
      .rdata (rdata_a)
   );

   svg_ram #(.WIDTH(2*AW), .DEPTH(DEPTH)) u_bank_b (
      .clock (clock),
      .we    (we_b),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (rd_addr),
      .rdata (rdata_b)
   );

   svg_alu #(.AMP_W(AW), .ACC_W(ACC_W)) u_alu (
      .clock  (clock),
      .ctl    (ctl),
      .in_re  (cur_data[2*AW-1:AW]),
      .in_im  (cur_data[AW-1:0]),
      .out_re (alu_re),
      .out_im (alu_im)
   );

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_strobe    = (state_ff == ST_RSP);
   assign rsp_read_real = res_re_ff;
   assign rsp_read_imag = res_im_ff;
   assign rsp_status    = status_ff;

endmodule
